[rtl/websocket_frame_header_parser_assert.svh]
// ----------------------------------------------------------------------------
// WebSocket frame header parser assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define WSFHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define WSFHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/wsfhp_pkg.sv]
// ----------------------------------------------------------------------------
// wsfhp_pkg
// Types, codes and constants of the WebSocket frame header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsfhp_pkg;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic        frame_done;
		logic        fin_flag;
		logic [3:0]  frame_opcode;
		logic [63:0] payload_length;
		logic [31:0] mask_key;
		logic [7:0]  payload_byte;
		logic [1:0]  error_code;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_HDR0,
		ST_HDR1,
		ST_EXT,
		ST_KEY,
		ST_DATA
	} parse_state_t;

	localparam logic       FUNC_CLEAR    = 1'b1;

	localparam logic [1:0] PH_HEADER     = 2'd0;
	localparam logic [1:0] PH_PAYLOAD    = 2'd1;
	localparam logic [1:0] PH_REJECTED   = 2'd2;
	localparam logic [1:0] PH_CLEARED    = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_RSV       = 2'd1;
	localparam logic [1:0] ERR_OPCODE    = 2'd2;
	localparam logic [1:0] ERR_MASK      = 2'd3;

	localparam logic [3:0] OPC_CONT      = 4'h0;
	localparam logic [3:0] OPC_TEXT      = 4'h1;
	localparam logic [3:0] OPC_BINARY    = 4'h2;
	localparam logic [3:0] OPC_CLOSE     = 4'h8;
	localparam logic [3:0] OPC_PING      = 4'h9;
	localparam logic [3:0] OPC_PONG      = 4'hA;

	localparam logic [7:0] RSV_MASK      = 8'h70;
	localparam logic [6:0] LEN_CODE_16   = 7'd126;
	localparam logic [6:0] LEN_CODE_64   = 7'd127;

	localparam logic [3:0] EXT16_BYTES   = 4'd2;
	localparam logic [3:0] EXT64_BYTES   = 4'd8;
	localparam logic [3:0] KEY_BYTES     = 4'd4;

	function automatic logic opcode_known(input logic [3:0] op);
		return (op == OPC_CONT) || (op == OPC_TEXT) || (op == OPC_BINARY) ||
			(op == OPC_CLOSE) || (op == OPC_PING) || (op == OPC_PONG);
	endfunction

endpackage

[rtl/websocket_frame_header_parser.sv]
// ----------------------------------------------------------------------------
// websocket_frame_header_parser
// Parses a client-to-server WebSocket byte stream, one byte per word.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and returns one result word per byte. Each
// byte is held in an input register, the frame state (FIN, opcode, length,
// masking key, payload countdown, sticky error) is updated from it, and the
// result lands in an output register. Throughput is one byte per cycle,
// set by the state update with its 64-bit payload countdown. Stalls on the
// output side hold both stages. A clear word (func = 1) returns the parser
// to frame start and clears a sticky error. Payload bytes are passed
// through as received; they are not unmasked.
`timescale 1ns / 1ps
`include "websocket_frame_header_parser_assert.svh"

module websocket_frame_header_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  wsfhp_pkg::in_word_t   in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output wsfhp_pkg::out_word_t  out_word
);

	logic                    valid_s1;
	wsfhp_pkg::in_word_t     word_s1;
	logic                    advance;
	logic                    step;

	wsfhp_pkg::parse_state_t parse_q, parse_d;
	logic                    fin_q, fin_d;
	logic [3:0]              opcode_q, opcode_d;
	logic [63:0]             len_q, len_d;
	logic [31:0]             key_q, key_d;
	logic [3:0]              cnt_q, cnt_d;
	logic [63:0]             rem_q, rem_d;
	logic [1:0]              err_q, err_d;

	logic [7:0]              b;
	logic [3:0]              cnt_dec;
	logic [3:0]              cnt_inc;
	logic [63:0]             rem_dec;

	logic [1:0]              phase;
	logic                    done;
	logic [7:0]              pbyte;

	logic                    out_valid_q;
	wsfhp_pkg::out_word_t    out_word_s2;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	assign b        = word_s1.data_byte;
	assign cnt_dec  = cnt_q - 4'd1;
	assign cnt_inc  = cnt_q + 4'd1;
	assign rem_dec  = rem_q - 64'd1;

	// hold input word while the result stage stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// next state
	always_comb begin
		parse_d  = parse_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		len_d    = len_q;
		key_d    = key_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		err_d    = err_q;
		if (word_s1.func == wsfhp_pkg::FUNC_CLEAR) begin
			parse_d  = wsfhp_pkg::ST_HDR0;
			fin_d    = 1'b0;
			opcode_d = wsfhp_pkg::OPC_CLOSE;
			len_d    = '0;
			key_d    = '0;
			cnt_d    = '0;
			rem_d    = '0;
			err_d    = wsfhp_pkg::ERR_NONE;
		end else if (err_q != wsfhp_pkg::ERR_NONE) begin
			parse_d = parse_q;
		end else begin
			unique case (parse_q)
				wsfhp_pkg::ST_HDR1: begin
					if (!b[7]) begin
						err_d = wsfhp_pkg::ERR_MASK;
					end else if (b[6:0] < wsfhp_pkg::LEN_CODE_16) begin
						len_d   = {57'd0, b[6:0]};
						cnt_d   = '0;
						parse_d = wsfhp_pkg::ST_KEY;
					end else begin
						len_d   = '0;
						cnt_d   = (b[6:0] == wsfhp_pkg::LEN_CODE_64) ?
							wsfhp_pkg::EXT64_BYTES : wsfhp_pkg::EXT16_BYTES;
						parse_d = wsfhp_pkg::ST_EXT;
					end
				end
				wsfhp_pkg::ST_EXT: begin
					len_d = {len_q[55:0], b};
					cnt_d = cnt_dec;
					if (cnt_dec == 4'd0) begin
						parse_d = wsfhp_pkg::ST_KEY;
					end
				end
				wsfhp_pkg::ST_KEY: begin
					key_d = {key_q[23:0], b};
					cnt_d = cnt_inc;
					if (cnt_inc >= wsfhp_pkg::KEY_BYTES) begin
						cnt_d = '0;
						if (len_q == 64'd0) begin
							parse_d = wsfhp_pkg::ST_HDR0;
						end else begin
							rem_d   = len_q;
							parse_d = wsfhp_pkg::ST_DATA;
						end
					end
				end
				wsfhp_pkg::ST_DATA: begin
					rem_d = rem_dec;
					if (rem_dec == 64'd0) begin
						parse_d = wsfhp_pkg::ST_HDR0;
					end
				end
				default: begin
					fin_d = b[7];
					if ((b & wsfhp_pkg::RSV_MASK) != 8'd0) begin
						err_d = wsfhp_pkg::ERR_RSV;
					end else if (!wsfhp_pkg::opcode_known(b[3:0])) begin
						err_d = wsfhp_pkg::ERR_OPCODE;
					end else begin
						opcode_d = b[3:0];
						len_d    = '0;
						key_d    = '0;
						cnt_d    = '0;
						rem_d    = '0;
						parse_d  = wsfhp_pkg::ST_HDR1;
					end
				end
			endcase
		end
	end

	// result outputs
	always_comb begin
		phase = wsfhp_pkg::PH_HEADER;
		done  = 1'b0;
		pbyte = 8'd0;
		if (word_s1.func == wsfhp_pkg::FUNC_CLEAR) begin
			phase = wsfhp_pkg::PH_CLEARED;
		end else if (err_q != wsfhp_pkg::ERR_NONE) begin
			phase = wsfhp_pkg::PH_REJECTED;
		end else begin
			unique case (parse_q)
				wsfhp_pkg::ST_HDR1: begin
					if (!b[7]) begin
						phase = wsfhp_pkg::PH_REJECTED;
					end
				end
				wsfhp_pkg::ST_EXT: begin
					phase = wsfhp_pkg::PH_HEADER;
				end
				wsfhp_pkg::ST_KEY: begin
					done = (cnt_inc >= wsfhp_pkg::KEY_BYTES) && (len_q == 64'd0);
				end
				wsfhp_pkg::ST_DATA: begin
					phase = wsfhp_pkg::PH_PAYLOAD;
					pbyte = b;
					done  = (rem_dec == 64'd0);
				end
				default: begin
					if (((b & wsfhp_pkg::RSV_MASK) != 8'd0) ||
						!wsfhp_pkg::opcode_known(b[3:0])) begin
						phase = wsfhp_pkg::PH_REJECTED;
					end
				end
			endcase
		end
	end

	// advance frame state once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q  <= wsfhp_pkg::ST_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= wsfhp_pkg::OPC_CLOSE;
			len_q    <= '0;
			key_q    <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
			err_q    <= wsfhp_pkg::ERR_NONE;
		end else if (step) begin
			parse_q  <= parse_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			len_q    <= len_d;
			key_q    <= key_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			err_q    <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_word_s2.phase          <= phase;
			out_word_s2.frame_done     <= done;
			out_word_s2.fin_flag       <= fin_d;
			out_word_s2.frame_opcode   <= opcode_d;
			out_word_s2.payload_length <= len_d;
			out_word_s2.mask_key       <= key_d;
			out_word_s2.payload_byte   <= pbyte;
			out_word_s2.error_code     <= err_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_s2;

	`WSFHP_ASSERT_NOW(a_pbyte_zero, clk, arst_n,
		out_valid_q && (out_word_s2.phase != wsfhp_pkg::PH_PAYLOAD),
		out_word_s2.payload_byte == 8'd0)
	`WSFHP_ASSERT_NOW(a_done_phase, clk, arst_n,
		out_valid_q && out_word_s2.frame_done,
		(out_word_s2.phase == wsfhp_pkg::PH_HEADER) ||
		(out_word_s2.phase == wsfhp_pkg::PH_PAYLOAD))
	`WSFHP_ASSERT_NOW(a_clear_resets, clk, arst_n,
		out_valid_q && (out_word_s2.phase == wsfhp_pkg::PH_CLEARED),
		(out_word_s2.error_code == wsfhp_pkg::ERR_NONE) &&
		(out_word_s2.payload_length == 64'd0) && (out_word_s2.mask_key == 32'd0))
	`WSFHP_ASSERT_NEXT(a_err_sticky, clk, arst_n,
		step && (err_q != wsfhp_pkg::ERR_NONE) &&
		(word_s1.func != wsfhp_pkg::FUNC_CLEAR),
		$stable(err_q) && $stable(parse_q))

endmodule

[dv/wsfhp_frame_checker.sv]
// ----------------------------------------------------------------------------
// wsfhp_frame_checker
// Watches both channels of the WebSocket frame header parser, tracks the
// frame state for every accepted input word, and compares each result word
// field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfhp_frame_checker
	import wsfhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_word_t    in_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_word_t   out_word,
	output int unsigned fail_count,
	output int unsigned pending
);

	parse_state_t hdr_state;
	logic         cur_fin;
	logic [3:0]   cur_opcode;
	logic [63:0]  cur_length;
	logic [31:0]  cur_key;
	logic [3:0]   byte_cnt;
	logic [63:0]  bytes_left;
	logic [1:0]   sticky_err;

	out_word_t due_results[$];
	out_word_t oldest;
	out_word_t predicted;

	task automatic clear_frame_state();
		hdr_state  = ST_HDR0;
		cur_fin    = 1'b0;
		cur_opcode = OPC_CLOSE;
		cur_length = '0;
		cur_key    = '0;
		byte_cnt   = '0;
		bytes_left = '0;
		sticky_err = ERR_NONE;
	endtask

	task automatic parse_byte(input in_word_t w, output out_word_t r);
		logic [1:0] ph;
		logic       done;
		logic [7:0] pass_byte;
		logic [7:0] b;
		ph        = PH_HEADER;
		done      = 1'b0;
		pass_byte = '0;
		b         = w.data_byte;
		if (w.func == FUNC_CLEAR) begin
			clear_frame_state();
			ph = PH_CLEARED;
		end else if (sticky_err != ERR_NONE) begin
			ph = PH_REJECTED;
		end else begin
			case (hdr_state)
				ST_HDR1: begin
					if (!b[7]) begin
						sticky_err = ERR_MASK;
						ph = PH_REJECTED;
					end else if (b[6:0] < LEN_CODE_16) begin
						cur_length = {57'd0, b[6:0]};
						byte_cnt   = '0;
						hdr_state  = ST_KEY;
					end else begin
						cur_length = '0;
						byte_cnt   = (b[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
						hdr_state  = ST_EXT;
					end
				end
				ST_EXT: begin
					cur_length = {cur_length[55:0], b};
					byte_cnt   = byte_cnt - 4'd1;
					if (byte_cnt == 4'd0)
						hdr_state = ST_KEY;
				end
				ST_KEY: begin
					cur_key  = {cur_key[23:0], b};
					byte_cnt = byte_cnt + 4'd1;
					if (byte_cnt >= KEY_BYTES) begin
						byte_cnt = '0;
						if (cur_length == 64'd0) begin
							done      = 1'b1;
							hdr_state = ST_HDR0;
						end else begin
							bytes_left = cur_length;
							hdr_state  = ST_DATA;
						end
					end
				end
				ST_DATA: begin
					ph         = PH_PAYLOAD;
					pass_byte  = b;
					bytes_left = bytes_left - 64'd1;
					if (bytes_left == 64'd0) begin
						done      = 1'b1;
						hdr_state = ST_HDR0;
					end
				end
				default: begin
					cur_fin = b[7];
					if ((b & RSV_MASK) != 8'd0) begin
						sticky_err = ERR_RSV;
						ph = PH_REJECTED;
					end else if (!(b[3:0] inside {OPC_CONT, OPC_TEXT, OPC_BINARY,
							OPC_CLOSE, OPC_PING, OPC_PONG})) begin
						sticky_err = ERR_OPCODE;
						ph = PH_REJECTED;
					end else begin
						cur_opcode = b[3:0];
						cur_length = '0;
						cur_key    = '0;
						byte_cnt   = '0;
						bytes_left = '0;
						hdr_state  = ST_HDR1;
					end
				end
			endcase
		end
		r.phase          = ph;
		r.frame_done     = done;
		r.fin_flag       = cur_fin;
		r.frame_opcode   = cur_opcode;
		r.payload_length = cur_length;
		r.mask_key       = cur_key;
		r.payload_byte   = pass_byte;
		r.error_code     = sticky_err;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame_state();
			due_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result word with none due: %h", out_word);
					fail_count++;
				end else begin
					oldest = due_results.pop_front();
					check_field("phase", 64'(oldest.phase), 64'(out_word.phase));
					check_field("frame_done", 64'(oldest.frame_done),
						64'(out_word.frame_done));
					check_field("fin_flag", 64'(oldest.fin_flag),
						64'(out_word.fin_flag));
					check_field("frame_opcode", 64'(oldest.frame_opcode),
						64'(out_word.frame_opcode));
					check_field("payload_length", oldest.payload_length,
						out_word.payload_length);
					check_field("mask_key", 64'(oldest.mask_key),
						64'(out_word.mask_key));
					check_field("payload_byte", 64'(oldest.payload_byte),
						64'(out_word.payload_byte));
					check_field("error_code", 64'(oldest.error_code),
						64'(out_word.error_code));
				end
			end
			if (in_valid && in_ready) begin
				parse_byte(in_word, predicted);
				due_results.push_back(predicted);
			end
			pending = due_results.size();
		end
	end

endmodule

[dv/tb_websocket_frame_header_parser.sv]
// ----------------------------------------------------------------------------
// tb_websocket_frame_header_parser
// Drives the frame header parser with directed frames and error cases, then
// random well-formed frames of every length encoding mixed with broken,
// truncated and noisy streams, under random sender bursts and receiver
// stalls. A side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_websocket_frame_header_parser;
	import wsfhp_pkg::*;

	localparam int unsigned RANDOM_WORDS = 500;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam logic        FUNC_DATA    = ~FUNC_CLEAR;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_word;
	int unsigned fail_count;
	int unsigned pending;

	int unsigned words_sent;
	int unsigned burst_left;
	int unsigned cycles;
	int unsigned stall_left;
	int unsigned mode_left;
	int unsigned rx_mode;
	bit          paused_mid;

	logic [3:0] good_ops [6] = '{OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG};

	websocket_frame_header_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	wsfhp_frame_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(1, 12);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	task automatic send_word(input logic f, input logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_word  <= '{func: f, data_byte: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_clear();
		send_word(FUNC_CLEAR, 8'($urandom));
	endtask

	// hold the sender until every predicted word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// send the first cut bytes of a frame with body payload bytes; clear if left open
	task automatic send_frame(input logic [7:0] hdr, input logic [6:0] code,
			input logic [63:0] len, input int unsigned body, input int unsigned cut);
		logic [7:0]  frame_bytes[$];
		logic [31:0] key;
		int unsigned ext;
		key = $urandom;
		frame_bytes.push_back(hdr);
		frame_bytes.push_back({1'b1, code});
		ext = (code == LEN_CODE_16) ? 2 : (code == LEN_CODE_64) ? 8 : 0;
		for (int i = ext - 1; i >= 0; i--)
			frame_bytes.push_back(len[i*8 +: 8]);
		for (int i = 3; i >= 0; i--)
			frame_bytes.push_back(key[i*8 +: 8]);
		repeat (body) frame_bytes.push_back(8'($urandom));
		for (int i = 0; i < frame_bytes.size() && i < cut; i++)
			send_word(FUNC_DATA, frame_bytes[i]);
		if (cut < frame_bytes.size() || 64'(body) < len)
			send_clear();
	endtask

	task automatic random_good_frame();
		logic [7:0]  hdr;
		logic [63:0] len;
		logic [6:0]  code;
		int unsigned body;
		int unsigned pick;
		hdr  = {1'($urandom), 3'b000, good_ops[$urandom_range(0, 5)]};
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(13, 125)) :
				64'($urandom_range(0, 12));
			code = len[6:0];
			body = 32'(len);
		end else if (pick < 85) begin
			code = LEN_CODE_16;
			len  = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 65535)) :
				64'($urandom_range(0, 24));
			body = (len > 64'd40) ? $urandom_range(0, 40) : 32'(len);
		end else begin
			code = LEN_CODE_64;
			if ($urandom_range(0, 2) == 0) begin
				len  = {$urandom, $urandom};
				body = $urandom_range(0, 6);
			end else begin
				len  = 64'($urandom_range(0, 20));
				body = 32'(len);
			end
		end
		send_frame(hdr, code, len, body, ($urandom_range(0, 9) == 0) ?
			$urandom_range(1, 12) : 32'hFFFF_FFFF);
	endtask

	task automatic random_broken_frame();
		logic [3:0] op;
		case ($urandom_range(0, 2))
			0: send_word(FUNC_DATA, {1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
			1: begin
				do op = 4'($urandom); while (op inside {OPC_CONT, OPC_TEXT, OPC_BINARY,
					OPC_CLOSE, OPC_PING, OPC_PONG});
				send_word(FUNC_DATA, {1'($urandom), 3'b000, op});
			end
			default: begin
				send_word(FUNC_DATA, {1'($urandom), 3'b000, good_ops[$urandom_range(0, 5)]});
				send_word(FUNC_DATA, {1'b0, 7'($urandom)});
			end
		endcase
		repeat ($urandom_range(0, 3)) send_word(FUNC_DATA, 8'($urandom));
		send_clear();
	endtask

	task automatic random_noise();
		repeat ($urandom_range(4, 20)) begin
			if ($urandom_range(0, 9) == 0)
				send_clear();
			else
				send_word(FUNC_DATA, 8'($urandom));
		end
		send_clear();
	endtask

	initial begin
		int unsigned pick;
		int unsigned directed_end;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_word    = '0;
		out_ready  = 1'b0;
		words_sent = 0;
		burst_left = 0;
		cycles     = 0;
		stall_left = 0;
		mode_left  = 0;
		rx_mode    = 0;
		paused_mid = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_clear();
		// empty frame: fourth key byte completes it
		send_word(FUNC_DATA, {1'b1, 3'b000, OPC_TEXT});
		send_word(FUNC_DATA, {1'b1, 7'd0});
		send_word(FUNC_DATA, 8'hFF);
		send_word(FUNC_DATA, 8'h00);
		send_word(FUNC_DATA, 8'hAA);
		send_word(FUNC_DATA, 8'h55);
		// two payload bytes, no FIN
		send_word(FUNC_DATA, {1'b0, 3'b000, OPC_BINARY});
		send_word(FUNC_DATA, {1'b1, 7'd2});
		repeat (4) send_word(FUNC_DATA, 8'($urandom));
		send_word(FUNC_DATA, 8'hFF);
		send_word(FUNC_DATA, 8'h00);
		// reserved bits set, then a rejected byte
		send_word(FUNC_DATA, {1'b1, 3'b111, OPC_PING});
		send_word(FUNC_DATA, {1'b1, 3'b000, OPC_TEXT});
		send_clear();
		// unknown opcode
		send_word(FUNC_DATA, {1'b1, 3'b000, 4'hB});
		send_clear();
		// mask bit clear
		send_word(FUNC_DATA, {1'b0, 3'b000, OPC_PONG});
		send_word(FUNC_DATA, {1'b0, 7'h7F});
		send_word(FUNC_DATA, 8'h80);
		send_clear();
		drain();

		directed_end = words_sent;
		while (words_sent < directed_end + RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				random_good_frame();
			else if (pick < 85)
				random_broken_frame();
			else
				random_noise();
			if (!paused_mid && words_sent > directed_end + RANDOM_WORDS / 2) begin
				paused_mid = 1'b1;
				drain();
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/wsfhp_pkg.sv
rtl/websocket_frame_header_parser.sv
dv/wsfhp_frame_checker.sv
dv/tb_websocket_frame_header_parser.sv
